// ===== src/mxbf_pkg.sv =====
// ----------------------------------------------------------------------------
// mxbf_pkg
// Shared types and constants of the multiply-xor buffer fingerprint core.
// ----------------------------------------------------------------------------
package mxbf_pkg;

  // Mixing constants
  localparam logic [63:0] K0 = 64'ha0761d6478bd642f;
  localparam logic [63:0] K1 = 64'he7037ed1a0b428db;
  localparam logic [63:0] K2 = 64'h8ebc6af09c88c6e3;
  localparam logic [63:0] K3 = 64'h589965cc75374cc3;

  // A block is 32 bytes, four words
  localparam int BLOCK_SHIFT = 5;

  // Default width of the sampled byte count
  localparam int LENGTH_BITS_DEF = 32;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MWAIT,
    ST_FIN_A,
    ST_FIN_A_WAIT,
    ST_FIN_B_WAIT,
    ST_DONE
  } state_t;

  // Where a word multiply writes back
  typedef enum logic [1:0] {
    DST_LANE0,
    DST_LANE1,
    DST_ACC_A
  } dst_t;

  // Request to the shared multiplier
  typedef struct packed {
    logic        start;
    logic [63:0] op_a;
    logic [63:0] op_b;
  } mul_req_t;

  // Status of the shared multiplier
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] value;
  } mul_rsp_t;

endpackage

// ===== src/mxbf_mul.sv =====
// ----------------------------------------------------------------------------
// mxbf_mul
// Iterative 64x64 -> 128 multiplier, one 32x32 partial product per cycle;
// the result is the xor of the two 64-bit halves of the product.
// ----------------------------------------------------------------------------
module mxbf_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  mxbf_pkg::mul_req_t req,
  output mxbf_pkg::mul_rsp_t rsp
);
  import mxbf_pkg::*;

  logic [63:0]  a_r, a_nxt;
  logic [63:0]  b_r, b_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;

  logic [31:0]  x_part;
  logic [31:0]  y_part;
  logic [63:0]  prod;
  logic [127:0] prod_sh;

  // Partial product for this step: cnt[1] picks the high half of a,
  // cnt[0] the high half of b
  always_comb begin
    x_part = cnt_r[1] ? a_r[63:32] : a_r[31:0];
    y_part = cnt_r[0] ? b_r[63:32] : b_r[31:0];
    prod   = 64'(x_part) * 64'(y_part);
    case (cnt_r)
      2'd0:    prod_sh = {64'd0, prod};
      2'd3:    prod_sh = {prod, 64'd0};
      default: prod_sh = {32'd0, prod, 32'd0};
    endcase
  end

  // Step control and accumulation
  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      a_nxt    = req.op_a;
      b_nxt    = req.op_b;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + prod_sh;
      cnt_nxt = cnt_r + 2'd1;
      if (cnt_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign rsp.busy  = busy_r;
  assign rsp.done  = done_r;
  assign rsp.value = acc_r[127:64] ^ acc_r[63:0];

  // Checks
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("mul done while busy");
  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == 2'd3 && !req.start) |=> done_r)
    else $error("mul did not finish after fourth step");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> (busy_r && cnt_r == 2'd0))
    else $error("mul start not taken");

endmodule

// ===== src/multiply_xor_buffer_fingerprint_core.sv =====
// ----------------------------------------------------------------------------
// multiply_xor_buffer_fingerprint_core
// 128-bit multiply-xor fingerprint of a byte buffer streamed as 64-bit words.
// ----------------------------------------------------------------------------
//  channel | signals                                 | direction
//  --------+-----------------------------------------+----------
//  input   | in_valid/in_ready, in_data_word,        | in
//          | in_total_bytes (first word only)        |
//  result  | out_valid/out_ready, out_hash_low,      | out
//          | out_hash_high (one per buffer)          |
//
//  A word without a multiply (block pair opener, partial tail, empty buffer)
//  passes through idle and exec only; a word with a multiply also waits out
//  the four steps of the shared 32x32 multiplier. The last word of a buffer
//  is followed by the two dependent finishing multiplies.
//  Reset (rst_n low, synchronous) returns to idle with the next word
//  starting a new buffer. A result left waiting on out_ready holds the core
//  in its done state once the next result is ready; no word is taken then.
// ----------------------------------------------------------------------------
module multiply_xor_buffer_fingerprint_core #(
  parameter int LENGTH_BITS = mxbf_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_word,
  input  logic [31:0] in_total_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hash_low,
  output logic [63:0] out_hash_high
);
  import mxbf_pkg::*;

  // Byte count can never exceed the 32-bit input field
  localparam int LEN_W = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;
  localparam int IDX_W = LEN_W - 3;

  state_t state_r, state_nxt;

  logic [63:0]      word_r, word_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [63:0]      acc_a_r, acc_a_nxt;
  logic [63:0]      acc_b_r, acc_b_nxt;
  logic [63:0]      lane0_r, lane0_nxt;
  logic [63:0]      lane1_r, lane1_nxt;
  logic [63:0]      held_r, held_nxt;
  logic [63:0]      a2_r, a2_nxt;
  logic [63:0]      b2_r, b2_nxt;
  logic             last_r, last_nxt;
  logic             blk_end_r, blk_end_nxt;
  dst_t             dst_r, dst_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [63:0]      out_low_r, out_low_nxt;
  logic [63:0]      out_high_r, out_high_nxt;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  // Word decode
  logic [63:0]      init_a;
  logic [IDX_W-1:0] blk_words;
  logic [IDX_W-1:0] full_words;
  logic [IDX_W:0]   num_words;
  logic [IDX_W:0]   idx_inc;
  logic             len_zero;
  logic             in_block;
  logic             tail_full;
  logic             is_last;
  logic             op_mul;
  logic [63:0]      mul_a;
  logic [63:0]      mul_b;
  dst_t             mul_dst;
  logic [2:0]       rem;
  logic [63:0]      tail_mix;
  logic             out_free;

  mxbf_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .rsp  (mul_rsp)
  );

  assign init_a     = {{(64 - LEN_W){1'b0}}, in_total_bytes[LEN_W-1:0]} ^ K0;
  assign blk_words  = {len_r[LEN_W-1:BLOCK_SHIFT], 2'b00};
  assign full_words = len_r[LEN_W-1:3];
  assign rem        = len_r[2:0];
  assign len_zero   = (len_r == '0);
  assign in_block   = (idx_r < blk_words);
  assign tail_full  = (idx_r < full_words);
  assign idx_inc    = {1'b0, idx_r} + 1'b1;
  assign out_free   = !out_valid_r || out_ready;

  // Word count, at least one for an empty buffer
  always_comb begin
    num_words = {1'b0, full_words} + {{IDX_W{1'b0}}, (rem != 3'd0)};
    if (num_words == '0) begin
      num_words = {{IDX_W{1'b0}}, 1'b1};
    end
  end
  assign is_last = (idx_inc >= num_words);

  // Operation for the current word
  always_comb begin
    op_mul  = 1'b0;
    mul_a   = word_r ^ K2;
    mul_b   = acc_a_r;
    mul_dst = DST_ACC_A;
    if (!len_zero) begin
      if (in_block) begin
        op_mul = idx_r[0];
        if (idx_r[1]) begin
          mul_a   = held_r ^ K1;
          mul_b   = word_r ^ lane1_r;
          mul_dst = DST_LANE1;
        end else begin
          mul_a   = held_r ^ K0;
          mul_b   = word_r ^ lane0_r;
          mul_dst = DST_LANE0;
        end
      end else begin
        op_mul = tail_full;
      end
    end
  end

  // Partial tail word: overlapping 4-byte or 3-byte picks
  always_comb begin
    tail_mix = '0;
    case (rem)
      3'd1: tail_mix = {40'd0, word_r[7:0], word_r[7:0], word_r[7:0]};
      3'd2: tail_mix = {40'd0, word_r[15:8], word_r[15:8], word_r[7:0]};
      3'd3: tail_mix = {40'd0, word_r[23:16], word_r[15:8], word_r[7:0]};
      3'd4: tail_mix = {word_r[31:0], word_r[31:0]};
      3'd5: tail_mix = {word_r[39:8], word_r[31:0]};
      3'd6: tail_mix = {word_r[47:16], word_r[31:0]};
      3'd7: tail_mix = {word_r[55:24], word_r[31:0]};
      default: tail_mix = '0;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (op_mul)       state_nxt = ST_MWAIT;
        else if (is_last) state_nxt = ST_FIN_A;
        else              state_nxt = ST_IDLE;
      end
      ST_MWAIT: begin
        if (mul_rsp.done) state_nxt = last_r ? ST_FIN_A : ST_IDLE;
      end
      ST_FIN_A: begin
        state_nxt = ST_FIN_A_WAIT;
      end
      ST_FIN_A_WAIT: begin
        if (mul_rsp.done) state_nxt = ST_FIN_B_WAIT;
      end
      ST_FIN_B_WAIT: begin
        if (mul_rsp.done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: input handshake and multiplier requests
  always_comb begin
    in_ready      = 1'b0;
    mul_req.start = 1'b0;
    mul_req.op_a  = mul_a;
    mul_req.op_b  = mul_b;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_EXEC: mul_req.start = op_mul;
      ST_FIN_A: begin
        mul_req.start = 1'b1;
        mul_req.op_a  = acc_a_r;
        mul_req.op_b  = acc_b_r ^ K2;
      end
      ST_FIN_A_WAIT: begin
        mul_req.start = mul_rsp.done;
        mul_req.op_a  = mul_rsp.value;
        mul_req.op_b  = acc_b_r ^ K3;
      end
      default: ;
    endcase
  end

  // Datapath register updates
  always_comb begin
    word_nxt      = word_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    acc_a_nxt     = acc_a_r;
    acc_b_nxt     = acc_b_r;
    lane0_nxt     = lane0_r;
    lane1_nxt     = lane1_r;
    held_nxt      = held_r;
    a2_nxt        = a2_r;
    b2_nxt        = b2_r;
    last_nxt      = last_r;
    blk_end_nxt   = blk_end_r;
    dst_nxt       = dst_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_low_nxt   = out_low_r;
    out_high_nxt  = out_high_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          word_nxt = in_data_word;
          // first word of a buffer seeds the state
          if (idx_r == '0) begin
            len_nxt   = in_total_bytes[LEN_W-1:0];
            acc_a_nxt = init_a;
            acc_b_nxt = K1;
            lane0_nxt = init_a;
            lane1_nxt = K1;
            held_nxt  = '0;
          end
        end
      end
      ST_EXEC: begin
        last_nxt    = is_last;
        blk_end_nxt = (idx_inc == {1'b0, blk_words});
        dst_nxt     = mul_dst;
        idx_nxt     = is_last ? '0 : idx_inc[IDX_W-1:0];
        if (!len_zero) begin
          if (in_block) begin
            if (!idx_r[0]) held_nxt = word_r;
          end else if (!tail_full) begin
            acc_b_nxt = acc_b_r ^ tail_mix;
          end
        end
      end
      ST_MWAIT: begin
        if (mul_rsp.done) begin
          case (dst_r)
            DST_LANE0: lane0_nxt = mul_rsp.value;
            DST_LANE1: begin
              lane1_nxt = mul_rsp.value;
              // end of the last full block folds lanes into accumulators
              if (blk_end_r) begin
                acc_a_nxt = lane0_r ^ K2;
                acc_b_nxt = mul_rsp.value ^ K3;
              end
            end
            default: acc_a_nxt = mul_rsp.value;
          endcase
        end
      end
      ST_FIN_A_WAIT: begin
        if (mul_rsp.done) a2_nxt = mul_rsp.value;
      end
      ST_FIN_B_WAIT: begin
        // high half is captured here and held in the done state until the output register is free
        if (mul_rsp.done) b2_nxt = mul_rsp.value;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_low_nxt   = a2_r;
          out_high_nxt  = b2_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    word_r     <= word_nxt;
    len_r      <= len_nxt;
    acc_a_r    <= acc_a_nxt;
    acc_b_r    <= acc_b_nxt;
    lane0_r    <= lane0_nxt;
    lane1_r    <= lane1_nxt;
    held_r     <= held_nxt;
    a2_r       <= a2_nxt;
    b2_r       <= b2_nxt;
    last_r     <= last_nxt;
    blk_end_r  <= blk_end_nxt;
    dst_r      <= dst_nxt;
    out_low_r  <= out_low_nxt;
    out_high_r <= out_high_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_hash_low  = out_low_r;
  assign out_hash_high = out_high_r;

  // Checks
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> (state_r == ST_MWAIT || state_r == ST_FIN_A_WAIT ||
                      state_r == ST_FIN_B_WAIT))
    else $error("multiplier finished outside a wait state");
  a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC || state_r == ST_FIN_A) |-> !mul_rsp.busy)
    else $error("multiplier started while busy");
  a_result_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (idx_r == '0))
    else $error("result given with buffer still open");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=>
      (out_valid_r && $stable(out_low_r) && $stable(out_high_r)))
    else $error("result changed while waiting");

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams byte buffers as 64-bit words into the fingerprint core and checks
// every 128-bit result against a cycle-free predictor of the hash. Both
// channels stall in random bursts, and one long result hold-off backs the
// core up into its input.
// ----------------------------------------------------------------------------
module testbench;
  import mxbf_pkg::*;

  localparam int STALL_LIMIT  = 2000;  // cycles with no request moving
  localparam int DRAIN_CYCLES = 40;    // worst word plus finishing multiplies
  localparam int WORD_TARGET  = 800;
  localparam int QUIET_TAIL   = 100;   // last words go without idling
  localparam int HOLD_AFTER   = 300;   // words accepted before the long hold
  localparam int HOLD_CYCLES  = 300;

  // How a buffer's bytes are filled
  typedef enum int {
    FILL_RANDOM,
    FILL_ONES,
    FILL_ZEROS
  } fill_t;

  typedef struct {
    logic [63:0] data;
    logic [31:0] total;
  } word_req_t;

  typedef struct {
    logic [63:0] low;
    logic [63:0] high;
  } fingerprint_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_data_word = '0;
  logic [31:0] in_total_bytes = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_hash_low;
  logic [63:0] out_hash_high;

  multiply_xor_buffer_fingerprint_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_word   (in_data_word),
    .in_total_bytes (in_total_bytes),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_low   (out_hash_low),
    .out_hash_high  (out_hash_high)
  );

  word_req_t    words_pending[$];
  fingerprint_t fingerprints_due[$];
  word_req_t    next_word;

  int words_total = 0;
  int buffers_total = 0;
  int words_sent = 0;
  int words_accepted = 0;
  int hashes_checked = 0;
  int error_count = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;

  // Hash state mirrored from the core
  logic [63:0] acc_a = '0;
  logic [63:0] acc_b = '0;
  logic [63:0] lane_zero = '0;
  logic [63:0] lane_one = '0;
  logic [63:0] held_word = '0;
  logic [63:0] word_pos = '0;
  logic [31:0] length_held = '0;

  initial begin
    forever #1 clk = ~clk;
  end

  // 64x64 product, high half folded onto low half
  function automatic logic [63:0] mul_fold(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] prod;
    prod = {64'b0, x} * {64'b0, y};
    return prod[127:64] ^ prod[63:0];
  endfunction

  function automatic logic [7:0] byte_at(input logic [63:0] w, input logic [63:0] pos);
    return w[pos[2:0]*8 +: 8];
  endfunction

  // Advance the hash by one word; queue the fingerprint on a buffer's last word
  task automatic absorb_word(input logic [63:0] w, input logic [31:0] total);
    logic [63:0] len;
    logic [63:0] word_count;
    logic [63:0] block_words;
    logic [63:0] rem;
    logic [63:0] tail;
    fingerprint_t fp;
    if (word_pos == 0) begin
      length_held = total;
      acc_a = {32'b0, total} ^ K0;
      acc_b = K1;
      lane_zero = acc_a;
      lane_one = acc_b;
      held_word = '0;
    end
    len = {32'b0, length_held};
    word_count = (len >> 3) + ((len[2:0] != 0) ? 64'd1 : 64'd0);
    if (word_count == 0) word_count = 1;
    block_words = (len >> BLOCK_SHIFT) << 2;

    if (len == 0) begin
      // empty buffer: data word carries nothing
    end else if (word_pos < block_words) begin
      case (word_pos[1:0])
        2'd0, 2'd2: held_word = w;
        2'd1: lane_zero = mul_fold(held_word ^ K0, w ^ lane_zero);
        default: begin
          lane_one = mul_fold(held_word ^ K1, w ^ lane_one);
          if (word_pos + 1 == block_words) begin
            acc_a = lane_zero ^ K2;
            acc_b = lane_one ^ K3;
          end
        end
      endcase
    end else begin
      rem = len - (word_pos << 3);
      if (rem >= 8) begin
        acc_a = mul_fold(w ^ K2, acc_a);
      end else if (rem >= 4) begin
        tail = w >> ((rem - 4) * 8);
        acc_b ^= {tail[31:0], w[31:0]};
      end else if (rem > 0) begin
        acc_b ^= {40'b0, byte_at(w, rem - 1), byte_at(w, rem >> 1), byte_at(w, 0)};
      end
    end

    if (word_pos + 1 >= word_count) begin
      fp.low = mul_fold(acc_a, acc_b ^ K2);
      fp.high = mul_fold(fp.low, acc_b ^ K3);
      fingerprints_due.push_back(fp);
      word_pos = '0;
    end else begin
      word_pos = word_pos + 1;
    end
  endtask

  // Split a buffer of len bytes into its words
  task automatic add_buffer(input int unsigned len, input fill_t fill);
    int unsigned n;
    word_req_t req;
    n = (len + 7) / 8;
    if (n == 0) n = 1;
    for (int unsigned k = 0; k < n; k++) begin
      case (fill)
        FILL_ONES: begin
          req.data = '1;
          req.total = '1;
        end
        FILL_ZEROS: begin
          req.data = '0;
          req.total = '0;
        end
        default: begin
          req.data = {$urandom, $urandom};
          req.total = $urandom;
        end
      endcase
      // length rides on the first word only
      if (k == 0) req.total = len;
      words_pending.push_back(req);
    end
    words_total += n;
    buffers_total++;
  endtask

  function automatic bit idling_allowed(input int count);
    return (words_pending.size() >= QUIET_TAIL) && ((count / 64) % 4 != 3);
  endfunction

  // Sender: new request or idle burst at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && words_accepted < words_sent) begin
        // request still waiting for ready
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (words_pending.size() == 0) begin
        in_valid <= 1'b0;
      end else if (idling_allowed(words_sent) && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 10);
        in_valid <= 1'b0;
      end else begin
        next_word = words_pending.pop_front();
        in_valid <= 1'b1;
        in_data_word <= next_word.data;
        in_total_bytes <= next_word.total;
        words_sent++;
      end
    end
  end

  // Receiver: ready bursts, plus one long hold-off to back up the core
  always @(negedge clk) begin
    if (rst_n) begin
      if (!long_hold_done && words_accepted >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (idling_allowed(words_accepted + 32) && $urandom_range(0, 4) == 0) begin
        recv_gap = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on accepted words, check accepted results, watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        absorb_word(in_data_word, in_total_bytes);
        words_accepted++;
      end
      if (out_valid && out_ready) begin
        if (fingerprints_due.size() == 0) begin
          $display("%0t: unexpected result: actual low %h high %h",
                   $time, out_hash_low, out_hash_high);
          error_count++;
        end else begin
          if (out_hash_low !== fingerprints_due[0].low) begin
            $display("%0t: hash_low mismatch: expected %h, actual %h",
                     $time, fingerprints_due[0].low, out_hash_low);
            error_count++;
          end
          if (out_hash_high !== fingerprints_due[0].high) begin
            $display("%0t: hash_high mismatch: expected %h, actual %h",
                     $time, fingerprints_due[0].high, out_hash_high);
            error_count++;
          end
          void'(fingerprints_due.pop_front());
          hashes_checked++;
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned len;
    int unsigned pick;
    fill_t fill;

    // Directed: empty buffers, tail sizes one to five and seven, block boundaries
    add_buffer(0, FILL_ONES);
    add_buffer(0, FILL_ZEROS);
    add_buffer(1, FILL_ONES);
    add_buffer(2, FILL_RANDOM);
    add_buffer(3, FILL_ZEROS);
    add_buffer(4, FILL_ONES);
    add_buffer(5, FILL_RANDOM);
    add_buffer(7, FILL_ONES);
    add_buffer(8, FILL_ZEROS);
    add_buffer(9, FILL_ONES);
    add_buffer(12, FILL_RANDOM);
    add_buffer(32, FILL_ONES);
    add_buffer(39, FILL_RANDOM);

    // Random buffers, mostly short, a few spanning several blocks
    while (words_total < WORD_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) len = $urandom_range(0, 40);
      else if (pick < 9) len = $urandom_range(41, 130);
      else len = $urandom_range(131, 260);
      pick = $urandom_range(0, 15);
      if (pick == 0) fill = FILL_ONES;
      else if (pick == 1) fill = FILL_ZEROS;
      else fill = FILL_RANDOM;
      add_buffer(len, fill);
    end

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    while (words_accepted < words_total) @(posedge clk);
    while (fingerprints_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d buffers as %0d words, including empty ones and every tail size.",
             buffers_total, words_total);
    $display("Checked %0d fingerprints through a %0d-cycle result hold-off.",
             hashes_checked, HOLD_CYCLES);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
